// File: rtl/auvm_pkg.sv
// Shared types and constants for the 16-bit service UUID matcher.
// Used by auvm_ltv_walker, adv_uuid16_matcher, auvm_checker and tb_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package auvm_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_UUID     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INCOMPLETE_TYPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLETE_TYPE   = 2'd2;

    localparam logic [15:0] TARGET_UUID_RST     = 16'h0000;
    localparam logic [7:0]  INCOMPLETE_TYPE_RST = 8'h02;
    localparam logic [7:0]  COMPLETE_TYPE_RST   = 8'h03;

    localparam logic [1:0] ROLE_NONE       = 2'd0;
    localparam logic [1:0] ROLE_INCOMPLETE = 2'd1;
    localparam logic [1:0] ROLE_COMPLETE   = 2'd2;

    typedef enum logic [2:0] {
        PHASE_LEN   = 3'b001,
        PHASE_TYPE  = 3'b010,
        PHASE_VALUE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [15:0] target_uuid;
        logic [7:0]  incomplete_type;
        logic [7:0]  complete_type;
    } cfg_t;

    typedef struct packed {
        logic       found;
        logic [1:0] list_used;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/auvm_ltv_walker.sv
// Length-type-value walker: per-report state and its one-byte update.
// Depends on auvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module auvm_ltv_walker (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire auvm_pkg::cfg_t   cfg,
    output auvm_pkg::result_t     result
);
    import auvm_pkg::*;

    logic [7:0] left_reg,  left_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] role_reg,  role_next;
    logic [7:0] low_reg,   low_next;
    logic       half_reg,  half_next;
    logic       inc_seen_reg,  inc_seen_next;
    logic       inc_match_reg, inc_match_next;
    logic       cmp_seen_reg,  cmp_seen_next;
    logic       cmp_match_reg, cmp_match_next;
    logic [7:0] left_dec;
    logic       uuid_hit;

    assign left_dec = left_reg - 8'd1;
    assign uuid_hit = ({data_byte, low_reg} == cfg.target_uuid);

    always_comb begin
        left_next      = left_reg;
        phase_next     = phase_reg;
        role_next      = role_reg;
        low_next       = low_reg;
        half_next      = half_reg;
        inc_seen_next  = inc_seen_reg;
        inc_match_next = inc_match_reg;
        cmp_seen_next  = cmp_seen_reg;
        cmp_match_next = cmp_match_reg;
        case (phase_reg)
            PHASE_LEN: begin
                if (data_byte != 8'd0) begin
                    left_next  = data_byte - 8'd1;
                    phase_next = PHASE_TYPE;
                end
            end
            PHASE_TYPE: begin
                role_next = ROLE_NONE;
                half_next = 1'b0;
                if (data_byte == cfg.incomplete_type && !inc_seen_reg) begin
                    role_next     = ROLE_INCOMPLETE;
                    inc_seen_next = 1'b1;
                end else if (data_byte == cfg.complete_type && !cmp_seen_reg) begin
                    role_next     = ROLE_COMPLETE;
                    cmp_seen_next = 1'b1;
                end
                phase_next = (left_reg == 8'd0) ? PHASE_LEN : PHASE_VALUE;
            end
            PHASE_VALUE: begin
                if (role_reg != ROLE_NONE) begin
                    if (!half_reg) begin
                        low_next  = data_byte;
                        half_next = 1'b1;
                    end else begin
                        half_next = 1'b0;
                        if (uuid_hit) begin
                            if (role_reg == ROLE_INCOMPLETE) begin
                                inc_match_next = 1'b1;
                            end else begin
                                cmp_match_next = 1'b1;
                            end
                        end
                    end
                end
                left_next = left_dec;
                if (left_dec == 8'd0) begin
                    phase_next = PHASE_LEN;
                end
            end
            default: begin
                phase_next = PHASE_LEN;
            end
        endcase
    end

    always_comb begin
        if (inc_seen_next) begin
            result.found     = inc_match_next;
            result.list_used = ROLE_INCOMPLETE;
        end else if (cmp_seen_next) begin
            result.found     = cmp_match_next;
            result.list_used = ROLE_COMPLETE;
        end else begin
            result.found     = 1'b0;
            result.list_used = ROLE_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            left_reg      <= 8'd0;
            phase_reg     <= PHASE_LEN;
            role_reg      <= ROLE_NONE;
            low_reg       <= 8'd0;
            half_reg      <= 1'b0;
            inc_seen_reg  <= 1'b0;
            inc_match_reg <= 1'b0;
            cmp_seen_reg  <= 1'b0;
            cmp_match_reg <= 1'b0;
        end else if (step) begin
            left_reg      <= left_next;
            phase_reg     <= phase_next;
            role_reg      <= role_next;
            low_reg       <= low_next;
            half_reg      <= half_next;
            inc_seen_reg  <= inc_seen_next;
            inc_match_reg <= inc_match_next;
            cmp_seen_reg  <= cmp_seen_next;
            cmp_match_reg <= cmp_match_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/adv_uuid16_matcher.sv
// Top level of the 16-bit service UUID matcher: input register, walker, result register.
// Depends on auvm_pkg and auvm_ltv_walker.
//
// Takes one advertising report byte per item (s_tlast on the final byte) and gives one
// result item per report: found and which UUID list was searched. Sustains one byte per
// clock; a report's result passes through the input register and then the result register
// on its way to m_tdata. The walker's combinational byte update sets that rate. Input
// stalls only while a finished result waits in the result register and the next last
// byte is ready to replace it.
// Configuration writes take effect on the next cycle and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module adv_uuid16_matcher (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [auvm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [auvm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tlast,   // last_byte
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata    // [0] found, [2:1] list_used
);
    import auvm_pkg::*;

    cfg_t       cfg_reg;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_vld_reg;
    result_t    out_res_reg;
    result_t    walk_res;
    logic       out_free;
    logic       step;

    assign out_free = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_uuid     <= TARGET_UUID_RST;
            cfg_reg.incomplete_type <= INCOMPLETE_TYPE_RST;
            cfg_reg.complete_type   <= COMPLETE_TYPE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET_UUID:     cfg_reg.target_uuid     <= cfg_wdata;
                REG_INCOMPLETE_TYPE: cfg_reg.incomplete_type <= cfg_wdata[7:0];
                REG_COMPLETE_TYPE:   cfg_reg.complete_type   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    auvm_ltv_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg_reg),
        .result    (walk_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step && in_last_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            out_res_reg <= walk_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_res_reg.list_used, out_res_reg.found};

endmodule

`default_nettype wire

// File: rtl/auvm_checker.sv
// Port-level checks on the UUID matcher's result channel, bound to adv_uuid16_matcher.
// Depends on auvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module auvm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    import auvm_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_list_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:1] == ROLE_NONE || m_tdata[2:1] == ROLE_INCOMPLETE
                      || m_tdata[2:1] == ROLE_COMPLETE))
        else $error("list_used holds an unused code");

    a_found_needs_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] != ROLE_NONE)
        else $error("found without a searched list");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("padding bits of result not zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind adv_uuid16_matcher auvm_checker u_auvm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for adv_uuid16_matcher: drives advertising reports byte by byte
// and checks each per-report verdict against a predictor of the LTV walk.
// Depends on auvm_pkg and the RTL of adv_uuid16_matcher.
`timescale 1ns / 1ps

module tb_top;
    import auvm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_PHASES   = 9;
    localparam int BYTES_PER_PHASE = 225;

    class uuid_scoreboard;
        logic [15:0] target;
        logic [7:0]  inc_type;
        logic [7:0]  comp_type;
        logic [7:0]  left_in_field;
        phase_t      walk_phase;
        logic [1:0]  role;
        logic [7:0]  low_byte;
        logic        half;
        logic        inc_seen, inc_hit, comp_seen, comp_hit;
        result_t     verdict_q[$];
        int          errors;

        function new();
            target    = TARGET_UUID_RST;
            inc_type  = INCOMPLETE_TYPE_RST;
            comp_type = COMPLETE_TYPE_RST;
            errors    = 0;
            clear_report();
        endfunction

        function void clear_report();
            left_in_field = 8'd0;
            walk_phase    = PHASE_LEN;
            role          = ROLE_NONE;
            low_byte      = 8'd0;
            half          = 1'b0;
            inc_seen      = 1'b0;
            inc_hit       = 1'b0;
            comp_seen     = 1'b0;
            comp_hit      = 1'b0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TARGET_UUID:     target    = val;
                REG_INCOMPLETE_TYPE: inc_type  = val[7:0];
                REG_COMPLETE_TYPE:   comp_type = val[7:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            result_t verdict;
            case (walk_phase)
                PHASE_LEN: begin
                    if (b != 8'd0) begin
                        left_in_field = b - 8'd1;
                        walk_phase    = PHASE_TYPE;
                    end
                end
                PHASE_TYPE: begin
                    role = ROLE_NONE;
                    half = 1'b0;
                    if (b == inc_type && !inc_seen) begin
                        role     = ROLE_INCOMPLETE;
                        inc_seen = 1'b1;
                    end else if (b == comp_type && !comp_seen) begin
                        role      = ROLE_COMPLETE;
                        comp_seen = 1'b1;
                    end
                    walk_phase = (left_in_field == 8'd0) ? PHASE_LEN : PHASE_VALUE;
                end
                default: begin
                    if (role != ROLE_NONE) begin
                        if (!half) begin
                            low_byte = b;
                            half     = 1'b1;
                        end else begin
                            if ({b, low_byte} == target) begin
                                if (role == ROLE_INCOMPLETE) inc_hit = 1'b1;
                                else comp_hit = 1'b1;
                            end
                            half = 1'b0;
                        end
                    end
                    left_in_field = left_in_field - 8'd1;
                    if (left_in_field == 8'd0) walk_phase = PHASE_LEN;
                end
            endcase
            if (last) begin
                if (inc_seen) begin
                    verdict.found     = inc_hit;
                    verdict.list_used = ROLE_INCOMPLETE;
                end else if (comp_seen) begin
                    verdict.found     = comp_hit;
                    verdict.list_used = ROLE_COMPLETE;
                end else begin
                    verdict.found     = 1'b0;
                    verdict.list_used = ROLE_NONE;
                end
                verdict_q.push_back(verdict);
                clear_report();
            end
        endfunction

        function void check_result(logic found, logic [1:0] list_used);
            result_t want;
            if (verdict_q.size() == 0) begin
                $error("unexpected result: found %0d, list_used %0d", found, list_used);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, found);
                errors++;
            end
            if (list_used !== want.list_used) begin
                $error("list_used: expected %0d, actual %0d", want.list_used, list_used);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;

    uuid_scoreboard sb;
    int             idle_pct;
    int             stall_pct;
    bit             hold_start;
    int             hold_left;
    int             cycle_count;
    int             phase_bytes;
    logic [7:0]     report_bytes[$];

    adv_uuid16_matcher u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata[0], m_tdata[2:1]);
        end
    end

    initial begin
        m_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_start) begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [15:0] uuid, logic [7:0] inc_t, logic [7:0] comp_t);
        write_reg(REG_TARGET_UUID, uuid);
        write_reg(REG_INCOMPLETE_TYPE, {8'($urandom_range(255)), inc_t});
        write_reg(REG_COMPLETE_TYPE, {8'($urandom_range(255)), comp_t});
        write_reg(REG_SPARE, 16'($urandom));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        phase_bytes++;
    endtask

    task automatic send_report();
        for (int i = 0; i < report_bytes.size(); i++)
            send_byte(report_bytes[i], i == report_bytes.size() - 1);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_uuid(logic [15:0] uuid);
        report_bytes.push_back(uuid[7:0]);
        report_bytes.push_back(uuid[15:8]);
    endtask

    task automatic build_report();
        int          nfields;
        int          npairs;
        int          pick;
        bit          odd;
        logic [7:0]  ftype;
        logic [15:0] uuid;
        report_bytes.delete();
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(12, 1)) report_bytes.push_back(8'($urandom));
            return;
        end
        nfields = $urandom_range(4);
        for (int f = 0; f < nfields; f++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                report_bytes.push_back(8'd0);
                continue;
            end
            ftype  = (pick < 4) ? sb.inc_type : (pick < 7) ? sb.comp_type : 8'($urandom);
            npairs = $urandom_range(4);
            odd    = ($urandom_range(3) == 0);
            report_bytes.push_back(8'(2 * npairs + odd + 1));
            report_bytes.push_back(ftype);
            for (int k = 0; k < npairs; k++) begin
                pick = $urandom_range(99);
                if (pick < 35) uuid = sb.target;
                else if (pick < 50) uuid = sb.target ^ (16'd1 << $urandom_range(15));
                else uuid = 16'($urandom);
                push_uuid(uuid);
            end
            if (odd) report_bytes.push_back(8'($urandom));
        end
        if (report_bytes.size() > 1 && $urandom_range(99) < 20)
            while (report_bytes.size() > 1 && $urandom_range(2) != 0)
                void'(report_bytes.pop_back());
        if (report_bytes.size() == 0) report_bytes.push_back(8'($urandom));
    endtask

    task automatic directed_reports();
        report_bytes = '{8'h00, 8'h03, 8'h03, 8'h0F, 8'h18};
        send_report();
        report_bytes = '{8'h04, 8'h02, 8'h0F, 8'h18, 8'hAA};
        send_report();
        report_bytes = '{8'h01, 8'h02, 8'h05, 8'h03, 8'h0F, 8'h18};
        send_report();
        report_bytes = '{8'hFF, 8'hFF};
        send_report();
        report_bytes = '{8'h02};
        send_report();
    endtask

    initial begin
        logic [7:0] same_type;
        sb          = new();
        cycle_count = 0;
        hold_start  = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tlast     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        configure(16'h180F, INCOMPLETE_TYPE_RST, COMPLETE_TYPE_RST);
        directed_reports();
        drain();

        for (int p = 1; p < NUM_PHASES; p++) begin
            case (p)
                1: configure(16'hFFFF, 8'h00, 8'hFF);
                2: configure(16'h0000, 8'hFF, 8'h00);
                3: begin
                    same_type = 8'($urandom);
                    configure(16'($urandom), same_type, same_type);
                end
                4, 7: configure(16'($urandom), INCOMPLETE_TYPE_RST, COMPLETE_TYPE_RST);
                default: configure(16'($urandom), 8'($urandom), 8'($urandom));
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            if (p == 4) hold_start = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) begin
                build_report();
                send_report();
            end
            drain();
        end

        stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: adv_uuid16_matcher.f
rtl/auvm_pkg.sv
rtl/auvm_ltv_walker.sv
rtl/adv_uuid16_matcher.sv
rtl/auvm_checker.sv
tb/sv/tb_top.sv
